FILE: src/stepper_axis_position_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the stepper axis position controller
// Shorthand for clocked implication checks with synchronous reset masking.
// ----------------------------------------------------------------------------
`ifndef STEPPER_AXIS_POSITION_CONTROLLER_MACROS_SVH
`define STEPPER_AXIS_POSITION_CONTROLLER_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold on that edge.
`define SAPC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication: when ante holds, cons must hold on the next edge.
`define SAPC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

FILE: src/sapc_pkg.sv
// ----------------------------------------------------------------------------
// sapc_pkg
// Shared types and constants of the stepper axis position controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sapc_pkg;

   // Command codes
   typedef enum logic [2:0] {
      CMD_START    = 3'd0,
      CMD_STOP     = 3'd1,
      CMD_PAUSE    = 3'd2,
      CMD_SETPOINT = 3'd3,
      CMD_MANUAL   = 3'd4,
      CMD_POSITION = 3'd5,
      CMD_RELEASE  = 3'd6
   } cmd_type;

   // Direction codes
   typedef enum logic [1:0] {
      DIR_IDLE = 2'd0,
      DIR_CW   = 2'd1,
      DIR_CCW  = 2'd2
   } dir_type;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_MAX_ANGLE     = 3'd0,
      CSR_STEP_ANGLE    = 3'd1,
      CSR_DEADBAND      = 3'd2,
      CSR_POSITION_GAIN = 3'd3,
      CSR_REVERSE_SENSE = 3'd4,
      CSR_POS_ERR_DIR   = 3'd5
   } csr_index_type;

   localparam int GAIN_FRAC_BITS = 12;
   // 17 x 17 signed product
   localparam int PROD_WIDTH     = 34;

   localparam logic [14:0] MAX_ANGLE_RST     = 15'd12000;
   localparam logic [11:0] STEP_ANGLE_RST    = 12'd14;
   localparam logic [11:0] DEADBAND_RST      = 12'd14;
   localparam logic [15:0] POSITION_GAIN_RST = 16'd6144;

endpackage

FILE: src/sapc_angle_sat.sv
// ----------------------------------------------------------------------------
// sapc_angle_sat
// Scales a product back to an angle: floor shift, saturate, optional negate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sapc_angle_sat #(
   parameter int ANGLE_WIDTH        = 16,
   parameter int SETPOINT_FRAC_BITS = 14
) (
   input  logic signed [sapc_pkg::PROD_WIDTH-1:0] product,
   input  logic                                   setpoint_scale,
   input  logic                                   negate,
   output logic signed [ANGLE_WIDTH-1:0]          angle
);

   localparam int PW = sapc_pkg::PROD_WIDTH;

   localparam logic signed [ANGLE_WIDTH-1:0] A_MAX = {1'b0, {(ANGLE_WIDTH-1){1'b1}}};
   localparam logic signed [ANGLE_WIDTH-1:0] A_MIN = {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
   localparam logic signed [PW-1:0] P_MAX = PW'(A_MAX);
   localparam logic signed [PW-1:0] P_MIN = PW'(A_MIN);

   logic signed [PW-1:0]          shifted;
   logic signed [ANGLE_WIDTH-1:0] clipped;

   // arithmetic shift rounds toward minus infinity
   assign shifted = setpoint_scale ? (product >>> SETPOINT_FRAC_BITS)
                                   : (product >>> sapc_pkg::GAIN_FRAC_BITS);

   always_comb begin
      priority if (shifted > P_MAX) begin
         clipped = A_MAX;
      end else if (shifted < P_MIN) begin
         clipped = A_MIN;
      end else begin
         clipped = shifted[ANGLE_WIDTH-1:0];
      end
   end

   // negating the most negative value saturates to the top
   always_comb begin
      if (!negate) begin
         angle = clipped;
      end else if (clipped == A_MIN) begin
         angle = A_MAX;
      end else begin
         angle = -clipped;
      end
   end

endmodule

FILE: src/stepper_axis_position_controller.sv
// ----------------------------------------------------------------------------
// stepper_axis_position_controller
// Bang-bang position controller for one stepper axis.
// ----------------------------------------------------------------------------
// Each command transfer on req_ yields exactly one status transfer on rsp_
// showing the axis state after that command. The block is a two-stage
// pipeline: the first stage holds the command with its one shared 17x17
// multiply (setpoint times travel, or encoder angle times gain), the second
// stage saturates the scaled angle, updates the axis state and loads the
// output register. A new command is taken every cycle while rsp_ flows;
// each command passes stage 1, then the output register. Angles are signed
// 1/16 degree and saturate at ANGLE_WIDTH bits. Neither req_ nor csr_ takes
// a transfer while reset is high. The csr_ port is otherwise always ready
// and should only be written while no command is in flight.
`timescale 1ns / 1ps

module stepper_axis_position_controller #(
   parameter int ANGLE_WIDTH        = 16,
   parameter int SETPOINT_FRAC_BITS = 14
) (
   input  logic        clock,
   input  logic        reset,
   // command stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // setpoint[15:0], drive_direction[17:16],
                                    // measured_angle[33:18], zeros[39:34]
   input  logic [2:0]  req_tuser,   // command[2:0]
   // status stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // motor_enable[0], pulses_running[1],
                                    // dir_level[2], direction_state[4:3],
                                    // angle_error[21:5],
                                    // current_position[37:22], zeros[39:38]
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

`include "stepper_axis_position_controller_macros.svh"

   localparam int AW    = ANGLE_WIDTH;
   localparam int PW    = sapc_pkg::PROD_WIDTH;
   localparam int CMP_W = (AW + 1 > 16) ? AW + 1 : 16;

   // ---------------------------------------------------------------- config
   logic [14:0] max_angle_ff;
   logic [11:0] step_angle_ff;
   logic [11:0] deadband_ff;
   logic [15:0] position_gain_ff;
   logic        reverse_sense_ff;
   logic        pos_err_dir_ff;

   assign csr_ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_angle_ff     <= sapc_pkg::MAX_ANGLE_RST;
         step_angle_ff    <= sapc_pkg::STEP_ANGLE_RST;
         deadband_ff      <= sapc_pkg::DEADBAND_RST;
         position_gain_ff <= sapc_pkg::POSITION_GAIN_RST;
         reverse_sense_ff <= 1'b1;
         pos_err_dir_ff   <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         unique case (sapc_pkg::csr_index_type'(csr_index))
            sapc_pkg::CSR_MAX_ANGLE:     max_angle_ff     <= csr_data[14:0];
            sapc_pkg::CSR_STEP_ANGLE:    step_angle_ff    <= csr_data[11:0];
            sapc_pkg::CSR_DEADBAND:      deadband_ff      <= csr_data[11:0];
            sapc_pkg::CSR_POSITION_GAIN: position_gain_ff <= csr_data;
            sapc_pkg::CSR_REVERSE_SENSE: reverse_sense_ff <= csr_data[0];
            sapc_pkg::CSR_POS_ERR_DIR:   pos_err_dir_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------- flow
   logic s1_valid_ff, s1_valid_in;
   logic out_valid_ff, out_valid_in;
   logic advance;
   logic req_xfer;
   logic s2_fire;

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = !reset && (!s1_valid_ff || advance);
   assign req_xfer   = req_tvalid && req_tready;
   assign s2_fire    = s1_valid_ff && advance;

   always_comb begin
      s1_valid_in  = req_xfer ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      out_valid_in = s2_fire ? 1'b1 : (rsp_tready ? 1'b0 : out_valid_ff);
   end

   // ---------------------------------------------------------------- stage 1
   logic [2:0]                  req_cmd;
   logic signed [15:0]          req_setpoint;
   logic [1:0]                  req_drive;
   logic signed [15:0]          req_measured;
   logic signed [16:0]          mul_a;
   logic signed [16:0]          mul_b;
   logic signed [PW-1:0]        product_in;
   sapc_pkg::dir_type           drive_in;

   logic [2:0]                  cmd_ff;
   sapc_pkg::dir_type           drive_ff;
   logic signed [PW-1:0]        product_ff;

   assign req_cmd      = req_tuser;
   assign req_setpoint = req_tdata[15:0];
   assign req_drive    = req_tdata[17:16];
   assign req_measured = req_tdata[33:18];

   // one multiplier serves both scalings
   always_comb begin
      if (req_cmd == sapc_pkg::CMD_POSITION) begin
         mul_a = {req_measured[15], req_measured};
         mul_b = {1'b0, position_gain_ff};
      end else begin
         mul_a = {req_setpoint[15], req_setpoint};
         mul_b = {2'b00, max_angle_ff};
      end
      product_in = PW'(mul_a * mul_b);
      // drive code 3 counts as idle
      if (req_drive == sapc_pkg::DIR_CW || req_drive == sapc_pkg::DIR_CCW) begin
         drive_in = sapc_pkg::dir_type'(req_drive);
      end else begin
         drive_in = sapc_pkg::DIR_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         cmd_ff     <= req_cmd;
         drive_ff   <= drive_in;
         product_ff <= product_in;
      end
   end

   // ---------------------------------------------------------------- stage 2
   logic signed [AW-1:0] scaled_angle;

   sapc_angle_sat #(
      .ANGLE_WIDTH        (ANGLE_WIDTH),
      .SETPOINT_FRAC_BITS (SETPOINT_FRAC_BITS)
   ) u_angle_sat (
      .product        (product_ff),
      .setpoint_scale (cmd_ff == sapc_pkg::CMD_SETPOINT),
      .negate         (reverse_sense_ff),
      .angle          (scaled_angle)
   );

   logic                 axis_active_ff, axis_active_in;
   logic                 pulses_on_ff, pulses_on_in;
   sapc_pkg::dir_type    stored_dir_ff, stored_dir_in;
   logic                 dir_pin_ff, dir_pin_in;
   logic signed [AW-1:0] axis_angle_ff, axis_angle_in;
   logic signed [AW-1:0] target_angle_ff, target_angle_in;
   logic [39:0]          rsp_tdata_ff, rsp_tdata_in;

   logic signed [AW-1:0] ctl_target;
   logic signed [AW:0]   ctl_err;
   logic [AW:0]          ctl_err_mag;
   logic [AW-1:0]        axis_mag;
   logic                 err_over_step;
   logic                 below_limit;
   sapc_pkg::dir_type    chosen_dir;
   logic signed [AW:0]   out_err;

   // error seen by the command: new target for a setpoint, else the held one
   always_comb begin
      ctl_target    = (cmd_ff == sapc_pkg::CMD_SETPOINT) ? scaled_angle : target_angle_ff;
      ctl_err       = {ctl_target[AW-1], ctl_target} - {axis_angle_ff[AW-1], axis_angle_ff};
      ctl_err_mag   = ctl_err[AW] ? (AW+1)'(-ctl_err) : ctl_err;
      axis_mag      = axis_angle_ff[AW-1] ? AW'(-axis_angle_ff) : axis_angle_ff;
      err_over_step = CMP_W'(ctl_err_mag) > CMP_W'(step_angle_ff);
      below_limit   = CMP_W'(axis_mag) < CMP_W'(max_angle_ff);
      priority if (CMP_W'(ctl_err_mag) < CMP_W'(deadband_ff)) begin
         chosen_dir = sapc_pkg::DIR_IDLE;
      end else if ((!ctl_err[AW] && ctl_err != '0) == pos_err_dir_ff) begin
         chosen_dir = sapc_pkg::DIR_CCW;
      end else begin
         chosen_dir = sapc_pkg::DIR_CW;
      end
   end

   always_comb begin
      axis_active_in  = axis_active_ff;
      pulses_on_in    = pulses_on_ff;
      stored_dir_in   = stored_dir_ff;
      dir_pin_in      = dir_pin_ff;
      axis_angle_in   = axis_angle_ff;
      target_angle_in = target_angle_ff;
      unique case (sapc_pkg::cmd_type'(cmd_ff))
         sapc_pkg::CMD_START: begin
            axis_active_in = 1'b1;
         end
         sapc_pkg::CMD_STOP: begin
            axis_active_in = 1'b0;
            pulses_on_in   = 1'b0;
            stored_dir_in  = sapc_pkg::DIR_IDLE;
         end
         sapc_pkg::CMD_PAUSE: begin
            pulses_on_in = 1'b0;
         end
         sapc_pkg::CMD_SETPOINT: begin
            target_angle_in = scaled_angle;
            if (!axis_active_ff) begin
               axis_active_in = 1'b0;
               pulses_on_in   = 1'b0;
               stored_dir_in  = sapc_pkg::DIR_IDLE;
            end else if (chosen_dir == sapc_pkg::DIR_IDLE) begin
               pulses_on_in = 1'b0;
            end else begin
               // pin only follows when the stored direction changes
               if (stored_dir_ff != chosen_dir) begin
                  stored_dir_in = chosen_dir;
                  dir_pin_in    = (chosen_dir == sapc_pkg::DIR_CW);
               end
               pulses_on_in = err_over_step;
            end
         end
         sapc_pkg::CMD_MANUAL: begin
            if (!axis_active_ff) begin
               axis_active_in = 1'b0;
               pulses_on_in   = 1'b0;
               stored_dir_in  = sapc_pkg::DIR_IDLE;
            end else if (drive_ff == sapc_pkg::DIR_IDLE) begin
               pulses_on_in = 1'b0;
            end else begin
               if (drive_ff != stored_dir_ff) begin
                  dir_pin_in = (drive_ff == sapc_pkg::DIR_CW);
               end
               // at the travel limit only a reversal may move the axis
               if (below_limit) begin
                  pulses_on_in  = 1'b1;
                  stored_dir_in = drive_ff;
               end else begin
                  pulses_on_in = (drive_ff != stored_dir_ff);
               end
            end
         end
         sapc_pkg::CMD_POSITION: begin
            axis_angle_in = scaled_angle;
         end
         sapc_pkg::CMD_RELEASE: begin
            if (stored_dir_ff == sapc_pkg::DIR_IDLE) begin
               pulses_on_in = 1'b0;
            end else begin
               if (stored_dir_ff != sapc_pkg::DIR_CW) begin
                  stored_dir_in = sapc_pkg::DIR_CW;
                  dir_pin_in    = 1'b1;
               end
               pulses_on_in = err_over_step;
            end
         end
         default: ;
      endcase
   end

   // status reflects the state after the command
   always_comb begin
      out_err      = {target_angle_in[AW-1], target_angle_in}
                   - {axis_angle_in[AW-1], axis_angle_in};
      rsp_tdata_in = {2'b00,
                      16'(axis_angle_in),
                      17'(out_err),
                      stored_dir_in,
                      dir_pin_in,
                      pulses_on_in,
                      axis_active_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_active_ff  <= 1'b0;
         pulses_on_ff    <= 1'b0;
         stored_dir_ff   <= sapc_pkg::DIR_IDLE;
         dir_pin_ff      <= 1'b0;
         axis_angle_ff   <= '0;
         target_angle_ff <= '0;
      end else if (s2_fire) begin
         axis_active_ff  <= axis_active_in;
         pulses_on_ff    <= pulses_on_in;
         stored_dir_ff   <= stored_dir_in;
         dir_pin_ff      <= dir_pin_in;
         axis_angle_ff   <= axis_angle_in;
         target_angle_ff <= target_angle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_fire) begin
         rsp_tdata_ff <= rsp_tdata_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // ---------------------------------------------------------------- checks
   // an idle axis never holds a direction or runs pulses
   `SAPC_ASSERT_SAME(a_idle_axis_quiet, clock, reset, !axis_active_ff,
      (stored_dir_ff == sapc_pkg::DIR_IDLE) && !pulses_on_ff)
   // a command held in the first stage is not dropped while output stalls
   `SAPC_ASSERT_NEXT(a_s1_held, clock, reset, s1_valid_ff && !advance, s1_valid_ff)
   // a command leaving the first stage always lands in the output register
   `SAPC_ASSERT_NEXT(a_s2_lands, clock, reset, s2_fire, out_valid_ff)

endmodule
